// ===== hw/rtl/looping_playback_time_accumulator_defines.svh =====
// Assertion helpers for the playback time accumulator.
// Each helper samples on i_clk and is switched off while i_rst_n is low.
`ifndef LOOPING_PLAYBACK_TIME_ACCUMULATOR_DEFINES_SVH
`define LOOPING_PLAYBACK_TIME_ACCUMULATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define LPTA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("playback accumulator: same-cycle check failed");

// Consequent checked in the cycle after the antecedent
`define LPTA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("playback accumulator: next-cycle check failed");

`endif

// ===== hw/rtl/lpta_pkg.sv =====
package lpta_pkg;

    localparam int PosW   = 32;
    localparam int DeltaW = 24;
    localparam int RateW  = 16;
    localparam int AccW   = DeltaW + RateW;
    localparam int RawW   = PosW + 2;
    localparam int DvdW   = PosW + 1;
    localparam int CntW   = 6;
    localparam int FracShift = 8;

    localparam logic [CntW-1:0] MulLast = CntW'(RateW - 1);
    localparam logic [CntW-1:0] DivLast = CntW'(DvdW - 1);

    localparam logic [RateW-1:0] RateReset = RateW'(256);

    // Register indexes on the configuration port
    localparam int RegIdxW = 3;
    localparam logic [RegIdxW-1:0] RegSeqPresent = 3'd0;
    localparam logic [RegIdxW-1:0] RegPlaying    = 3'd1;
    localparam logic [RegIdxW-1:0] RegReverse    = 3'd2;
    localparam logic [RegIdxW-1:0] RegLoop       = 3'd3;
    localparam logic [RegIdxW-1:0] RegRate       = 3'd4;
    localparam logic [RegIdxW-1:0] RegLength     = 3'd5;

    // Request function codes
    localparam logic FuncAdvance = 1'b0;
    localparam logic FuncReset   = 1'b1;

    typedef struct packed {
        logic              func;
        logic [DeltaW-1:0] delta_time;
    } t_in_item;

    typedef struct packed {
        logic [PosW-1:0] prior_position;
        logic [PosW-1:0] new_position;
        logic            advanced;
        logic            wrapped;
        logic            hit_end;
    } t_out_item;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_DIV  = 6'b001000,
        S_FIX  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

endpackage

// ===== hw/rtl/looping_playback_time_accumulator.sv =====
// Playback position accumulator, unsigned Q16.16 seconds. One request is worked on at a
// time and gives one result. A position reset, or an advance while unbound, stopped or
// with zero length, goes straight to the output state. A moving advance runs the
// bit-serial multiply of the delta by the rate magnitude (one rate bit per cycle), then
// adds the step and clamps it or checks for a wrap, then loads the output register. In
// loop mode a sum that leaves [0, length) first passes the restoring modulo unit (one
// quotient bit per cycle) and a step that folds a negative remainder. A new request is
// taken the cycle after the previous result has moved to the output register, which may
// still be waiting to be taken.
`include "looping_playback_time_accumulator_defines.svh"

module looping_playback_time_accumulator
    import lpta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic             r_seq_present;
    logic             r_playing;
    logic             r_reverse;
    logic             r_loop;
    logic [RateW-1:0] r_rate;
    logic [PosW-1:0]  r_len;

    // Working state
    t_state           r_state;
    logic [PosW-1:0]  r_pos;
    logic [CntW-1:0]  r_cnt;
    logic [AccW-1:0]  r_acc;
    logic [RateW-1:0] r_mq;
    logic [DeltaW-1:0] r_delta;
    logic             r_neg;
    logic [DvdW-1:0]  r_dvd;
    logic [PosW-1:0]  r_rem;
    t_out_item        r_res;

    // Output register
    logic             r_out_valid;
    t_out_item        r_out;

    logic [RegIdxW-1:0] cfg_idx;
    logic               cfg_wr;
    logic               accept;
    logic               out_load;
    logic [RateW-1:0]   rate_mag;
    logic [AccW-1:0]    n_acc;
    logic [PosW-1:0]    step_mag;
    logic [RawW-1:0]    n_raw;
    logic [DvdW-1:0]    raw_abs;
    logic               raw_neg;
    logic               raw_ge_len;
    logic               raw_gt_len;
    logic               raw_zero;
    logic [DvdW-1:0]    n_trial;
    logic [PosW-1:0]    n_rem;

    // Register port
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb begin
        case (cfg_idx)
            RegSeqPresent: prdata = {31'd0, r_seq_present};
            RegPlaying:    prdata = {31'd0, r_playing};
            RegReverse:    prdata = {31'd0, r_reverse};
            RegLoop:       prdata = {31'd0, r_loop};
            RegRate:       prdata = {16'd0, r_rate};
            RegLength:     prdata = r_len;
            default:       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_present <= 1'b0;
            r_playing     <= 1'b0;
            r_reverse     <= 1'b0;
            r_loop        <= 1'b0;
            r_rate        <= RateReset;
            r_len         <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                RegSeqPresent: r_seq_present <= pwdata[0];
                RegPlaying:    r_playing     <= pwdata[0];
                RegReverse:    r_reverse     <= pwdata[0];
                RegLoop:       r_loop        <= pwdata[0];
                RegRate:       r_rate        <= pwdata[RateW-1:0];
                RegLength:     r_len         <= pwdata[PosW-1:0];
                default:       ;
            endcase
        end
    end

    // Handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Rate magnitude; sign folds into the step direction
    assign rate_mag = r_rate[RateW-1] ? (~r_rate + RateW'(1)) : r_rate;

    // One multiplier bit per cycle, most significant first
    assign n_acc = {r_acc[AccW-2:0], 1'b0} + (r_mq[RateW-1] ? AccW'(r_delta) : AccW'(0));

    // Add or subtract the truncated step to or from the position
    assign step_mag = r_acc[FracShift +: PosW];
    assign n_raw    = r_neg ? (RawW'(r_pos) - RawW'(step_mag))
                            : (RawW'(r_pos) + RawW'(step_mag));
    assign raw_neg    = n_raw[RawW-1];
    assign raw_abs    = raw_neg ? DvdW'(~n_raw + RawW'(1)) : n_raw[DvdW-1:0];
    assign raw_ge_len = !raw_neg && (n_raw[DvdW-1:0] >= DvdW'(r_len));
    assign raw_gt_len = !raw_neg && (n_raw[DvdW-1:0] >  DvdW'(r_len));
    assign raw_zero   = (n_raw == '0);

    // One restoring modulo step per cycle
    assign n_trial = {r_rem, r_dvd[DvdW-1]};
    assign n_rem   = (n_trial >= DvdW'(r_len)) ? PosW'(n_trial - DvdW'(r_len))
                                               : n_trial[PosW-1:0];

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res.advanced       <= 1'b0;
                        r_res.wrapped        <= 1'b0;
                        r_res.hit_end        <= 1'b0;
                        r_delta              <= i_in_data.delta_time;
                        r_mq                 <= rate_mag;
                        r_acc                <= '0;
                        r_neg                <= r_reverse ^ r_rate[RateW-1];
                        r_cnt                <= '0;
                        if (i_in_data.func == FuncReset) begin
                            r_res.prior_position <= r_pos;
                            r_res.new_position   <= '0;
                            r_state              <= S_OUT;
                        end else if (!(r_seq_present && r_playing)) begin
                            r_res.prior_position <= r_pos;
                            r_res.new_position   <= r_pos;
                            r_state              <= S_OUT;
                        end else if (r_len == '0) begin
                            r_res.prior_position <= '0;
                            r_res.new_position   <= '0;
                            r_state              <= S_OUT;
                        end else begin
                            r_res.prior_position <= r_pos;
                            r_state              <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_acc <= n_acc;
                    r_mq  <= {r_mq[RateW-2:0], 1'b0};
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == MulLast) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_res.advanced <= 1'b1;
                    r_cnt          <= '0;
                    r_dvd          <= raw_abs;
                    r_rem          <= '0;
                    r_neg          <= raw_neg;
                    if (r_loop) begin
                        r_res.wrapped <= raw_ge_len || raw_neg;
                        if (raw_ge_len || raw_neg) begin
                            r_state <= S_DIV;
                        end else begin
                            r_res.new_position <= n_raw[PosW-1:0];
                            r_state            <= S_OUT;
                        end
                    end else begin
                        r_res.hit_end <= (!r_reverse && raw_ge_len)
                                      || (r_reverse && (raw_neg || raw_zero));
                        if (raw_neg) begin
                            r_res.new_position <= '0;
                        end else if (raw_gt_len) begin
                            r_res.new_position <= r_len;
                        end else begin
                            r_res.new_position <= n_raw[PosW-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_dvd <= {r_dvd[DvdW-2:0], 1'b0};
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == DivLast) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    // Fold a negative sum back into [0, length)
                    if (r_neg && (r_rem != '0)) begin
                        r_res.new_position <= r_len - r_rem;
                    end else begin
                        r_res.new_position <= r_rem;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_pos   <= r_res.new_position;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register: hold while stalled, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    `LPTA_ASSERT_NEXT(a_accept_leaves_idle, accept, r_state != S_IDLE)
    `LPTA_ASSERT_SAME(a_flags_exclusive, o_out_valid,
        !(o_out_data.wrapped && o_out_data.hit_end))
    `LPTA_ASSERT_SAME(a_flags_need_advance, o_out_valid && !o_out_data.advanced,
        !o_out_data.wrapped && !o_out_data.hit_end)
    `LPTA_ASSERT_NEXT(a_mul_moves_to_sum, r_state == S_MUL,
        r_state == S_MUL || r_state == S_SUM)

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import lpta_pkg::*;

    localparam int RandPhases  = 25;
    localparam int PhaseItems  = 50;
    localparam int QuietLimit  = 2000;
    localparam int ReportLimit = 10;
    localparam int DrainCycles = 60;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        i_out_stall = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [4:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_data;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block's registers and playhead state
    logic        cfg_present;
    logic        cfg_playing;
    logic        cfg_reverse;
    logic        cfg_loop;
    logic [15:0] cfg_rate;
    logic [31:0] cfg_length;
    logic [31:0] play_pos;
    logic [31:0] last_pos;

    t_in_item    pending_requests[$];
    t_out_item   expected_reports[$];
    t_out_item   want;

    bit          bursts_on = 1'b1;
    int          gap_left;
    int          stall_left;
    int          quiet_cycles;
    int          n_errors;
    int          n_requests;
    int          n_resets;
    int          n_results;
    int          n_wraps;
    int          n_end_hits;
    int          n_reg_writes;

    looping_playback_time_accumulator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void log_error(string msg);
        n_errors++;
        if (n_errors <= ReportLimit) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val) begin
            log_error($sformatf("%s expected %0h got %0h", name, exp_val, got));
        end
    endfunction

    // Work out the report for one request and advance the shadow playhead
    function automatic t_out_item step_playhead(t_in_item req);
        t_out_item res;
        longint    len_l;
        longint    pos_l;
        longint    rmag;
        longint    mag;
        longint    raw;
        longint    rem;
        logic      neg;
        res = '0;
        res.prior_position = play_pos;
        len_l = longint'(cfg_length);
        pos_l = longint'(play_pos);
        if (req.func == FuncReset) begin
            play_pos = '0;
            last_pos = '0;
            n_resets++;
        end else if (cfg_present && cfg_playing) begin
            if (len_l == 0) begin
                play_pos = '0;
                last_pos = '0;
                res.prior_position = '0;
            end else begin
                last_pos = play_pos;
                // Scale by the rate magnitude; the sign folds into the direction
                rmag = longint'($signed(cfg_rate));
                neg  = cfg_reverse;
                if (rmag < 0) begin
                    rmag = -rmag;
                    neg  = !neg;
                end
                mag = longint'(req.delta_time);
                mag = (mag * rmag) >>> 8;
                raw = neg ? pos_l - mag : pos_l + mag;
                res.advanced = 1'b1;
                if (cfg_loop) begin
                    // Wrap by a true modulo, negative sums folded up from the top
                    res.wrapped = (raw >= len_l) || (raw < 0);
                    if (raw >= 0) begin
                        play_pos = 32'(raw % len_l);
                    end else begin
                        rem = (-raw) % len_l;
                        play_pos = (rem == 0) ? 32'd0 : 32'(len_l - rem);
                    end
                    if (res.wrapped) n_wraps++;
                end else begin
                    // Clamp; the end flag follows the mode, not the actual direction
                    res.hit_end = (!cfg_reverse && raw >= len_l) || (cfg_reverse && raw <= 0);
                    if (raw < 0) begin
                        play_pos = '0;
                    end else if (raw > len_l) begin
                        play_pos = cfg_length;
                    end else begin
                        play_pos = 32'(raw);
                    end
                    if (res.hit_end) n_end_hits++;
                end
            end
        end
        res.new_position = play_pos;
        return res;
    endfunction

    function automatic bit still_busy();
        return pending_requests.size() != 0 || i_in_valid || expected_reports.size() != 0;
    endfunction

    // Request driver: present queued requests, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_reports.push_back(step_playhead(i_in_data));
                n_requests++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_requests.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 14) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_requests.pop_front();
                end
            end
        end
    end

    // Result monitor: compare each taken result and stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_reports.size() == 0) begin
                    log_error($sformatf("result with nothing expected: %p", o_out_data));
                end else begin
                    want = expected_reports.pop_front();
                    check_field("prior_position", o_out_data.prior_position,
                                want.prior_position);
                    check_field("new_position", o_out_data.new_position, want.new_position);
                    check_field("advanced", 32'(o_out_data.advanced), 32'(want.advanced));
                    check_field("wrapped", 32'(o_out_data.wrapped), 32'(want.wrapped));
                    check_field("hit_end", 32'(o_out_data.hit_end), 32'(want.hit_end));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (i_out_stall || !bursts_on) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: give up when work is pending and nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !still_busy()) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("Timeout: no progress for %0d cycles", QuietLimit);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hold until every expected result is back and the block has gone idle
    task automatic wait_settled();
        do @(negedge i_clk); while (still_busy());
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_reg_writes++;
        case (idx)
            RegSeqPresent: cfg_present = val[0];
            RegPlaying:    cfg_playing = val[0];
            RegReverse:    cfg_reverse = val[0];
            RegLoop:       cfg_loop    = val[0];
            RegRate:       cfg_rate    = val[15:0];
            RegLength:     cfg_length  = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(input logic present, input logic playing, input logic reverse,
                            input logic loop_on, input logic [15:0] rate,
                            input logic [31:0] length);
        wait_settled();
        reg_write(RegSeqPresent, 32'(present));
        reg_write(RegPlaying, 32'(playing));
        reg_write(RegReverse, 32'(reverse));
        reg_write(RegLoop, 32'(loop_on));
        reg_write(RegRate, 32'(rate));
        reg_write(RegLength, length);
        @(negedge i_clk);
    endtask

    task automatic queue_request(input logic func, input logic [DeltaW-1:0] delta);
        t_in_item req;
        req.func       = func;
        req.delta_time = delta;
        pending_requests.push_back(req);
    endtask

    function automatic logic [DeltaW-1:0] pick_delta();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return DeltaW'($urandom);
            default: return DeltaW'($urandom_range(1, 24'h03_FFFF));
        endcase
    endfunction

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return RateReset;
            4:       return 16'hFF00;
            5:       return 16'hFFFF;
            6, 7:    return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3, 4, 5: return 32'($urandom);
            default: return 32'($urandom_range(32'h0000_0100, 32'h0010_0000));
        endcase
    endfunction

    // Stimulus: directed corners, then random phases with fresh register settings
    initial begin
        cfg_present = 1'b0;
        cfg_playing = 1'b0;
        cfg_reverse = 1'b0;
        cfg_loop    = 1'b0;
        cfg_rate    = RateReset;
        cfg_length  = '0;
        play_pos    = '0;
        last_pos    = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // No sequence bound: position reported unchanged, then a position reset
        queue_request(FuncAdvance, 24'hFF_FFFF);
        queue_request(FuncReset, 24'hFF_FFFF);

        // Bound but stopped
        set_mode(1'b1, 1'b0, 1'b0, 1'b0, RateReset, 32'h000A_0000);
        queue_request(FuncAdvance, 24'h01_0000);

        // Zero length empties the position
        set_mode(1'b1, 1'b1, 1'b0, 1'b0, RateReset, 32'd0);
        queue_request(FuncAdvance, 24'h01_0000);

        // Forward clamp up to the end
        set_mode(1'b1, 1'b1, 1'b0, 1'b0, RateReset, 32'h000A_0000);
        repeat (4) queue_request(FuncAdvance, 24'h03_0000);
        queue_request(FuncAdvance, 24'h00_0000);

        // Reverse clamp down to zero
        set_mode(1'b1, 1'b1, 1'b1, 1'b0, RateReset, 32'h000A_0000);
        repeat (3) queue_request(FuncAdvance, 24'h05_0000);

        // Reverse with a negative rate moves forward, no end flag
        set_mode(1'b1, 1'b1, 1'b1, 1'b0, 16'hFF00, 32'h000A_0000);
        queue_request(FuncAdvance, 24'h02_0000);

        // Loop: a sum of exactly the length wraps to zero
        set_mode(1'b1, 1'b1, 1'b0, 1'b1, RateReset, 32'h0003_0000);
        queue_request(FuncReset, 24'h00_0000);
        queue_request(FuncAdvance, 24'h03_0000);
        queue_request(FuncAdvance, 24'h01_0000);

        // Loop backwards: an exact negative multiple folds to zero
        set_mode(1'b1, 1'b1, 1'b0, 1'b1, 16'hFF00, 32'h0003_0000);
        queue_request(FuncReset, 24'h00_0000);
        queue_request(FuncAdvance, 24'h03_0000);
        queue_request(FuncAdvance, 24'h01_8000);

        // Extreme rate and length in loop mode
        set_mode(1'b1, 1'b1, 1'b1, 1'b1, 16'h8000, 32'hFFFF_FFFF);
        queue_request(FuncReset, 24'h00_0000);
        repeat (2) queue_request(FuncAdvance, 24'hFF_FFFF);
        set_mode(1'b1, 1'b1, 1'b0, 1'b1, 16'h8000, 32'h0003_0000);
        queue_request(FuncAdvance, 24'hFF_FFFF);
        set_mode(1'b1, 1'b1, 1'b0, 1'b1, 16'h7FFF, 32'h0003_0000);
        queue_request(FuncAdvance, 24'hFF_FFFF);

        // Random phases; the last one runs without gaps or stalls
        for (int ph = 0; ph < RandPhases; ph++) begin
            set_mode(1'($urandom_range(0, 9) != 0), 1'($urandom_range(0, 9) != 0),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     pick_rate(), pick_length());
            if (ph == RandPhases - 1) bursts_on = 1'b0;
            for (int k = 0; k < PhaseItems; k++) begin
                queue_request(($urandom_range(0, 19) == 0) ? FuncReset : FuncAdvance,
                              pick_delta());
            end
        end

        wait_settled();
        repeat (DrainCycles) @(negedge i_clk);
        if (expected_reports.size() != 0) begin
            log_error($sformatf("%0d results never arrived", expected_reports.size()));
        end

        $display("Covered %0d requests (%0d position resets) over %0d register writes,",
                 n_requests, n_resets, n_reg_writes);
        $display("%0d results checked, %0d loop wraps, %0d clamp end hits, %0d mismatches",
                 n_results, n_wraps, n_end_hits, n_errors);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== looping_playback_time_accumulator.f =====
+incdir+hw/rtl
hw/rtl/lpta_pkg.sv
hw/rtl/looping_playback_time_accumulator.sv
sim/tb_top.sv
